// ===== rtl/sbo_pkg.sv =====
// sbo_pkg: shared types and constants of the slab bitmap object allocator
// request/result payload structs, status and occupancy codes,
// controller-datapath command and status structs; no dependencies
package sbo_pkg;

  localparam int unsigned SLOT_W    = 9;
  localparam int unsigned CNT_W     = 10;
  localparam int unsigned OBJ_W     = 13;
  localparam int unsigned OFF_W     = 21;
  localparam int unsigned PROD_W    = SLOT_W + OBJ_W;
  localparam int unsigned WORD_BITS = 64;
  localparam int unsigned BIT_W     = 6;
  localparam int unsigned BASE_W    = 11;
  localparam int unsigned SLOT_LIMIT = 512;

  localparam logic [OFF_W-1:0] OFFSET_MAX = 21'h1F_FFFF;

  // request kinds
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_NO_SLOT     = 2'd1;
  localparam logic [1:0] ST_DOUBLE_FREE = 2'd2;
  localparam logic [1:0] ST_RANGE       = 2'd3;

  // slab occupancy codes
  localparam logic [1:0] OCC_EMPTY   = 2'd0;
  localparam logic [1:0] OCC_PARTIAL = 2'd1;
  localparam logic [1:0] OCC_FULL    = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_USE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_OBJECT_BYTES = 1'b1;

  localparam logic [CNT_W-1:0] SLOTS_RESET = 10'd512;
  localparam logic [OBJ_W-1:0] OBJ_RESET   = 13'd8;

  typedef struct packed {
    logic              kind;
    logic [SLOT_W-1:0] slot_index;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [SLOT_W-1:0] slot_out;
    logic [OFF_W-1:0]  byte_offset;
    logic [1:0]        slab_state;
    logic [CNT_W-1:0]  used_count;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic mult;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic decided;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== rtl/slab_bitmap_object_allocator_top.sv =====
// Slab bitmap object allocator, top level.
// Request channel (req_valid / req_stall / req_data): kind 0 allocates the
// lowest free slot below the slot limit, kind 1 frees req_data.slot_index.
// Result channel (rsp_valid / rsp_stall / rsp_data): one result per request
// with status, slot, byte offset (slot times object size, saturated),
// slab state and used count after the request.
// Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): index 0 slot
// count, index 1 object size; always ready, write only while idle.
// Scan: an allocation checks the 64-bit bitmap words in turn from word 0 up to
// the hit or the last word below the slot limit; a free checks only the word
// of its slot. The bitmap memory reads one word per cycle. One request is in
// flight at a time; the next is taken in the cycle after the result is loaded.
// Reset (rst, synchronous): bitmap reads as all free, count zero, slab empty,
// slot count 512, object size 8; no clearing pass is needed.
// A stalled result holds in the output register; the block finishes the next
// request up to the hand-off and then waits.
// depends on sbo_pkg, sbo_ctrl, sbo_dp
module slab_bitmap_object_allocator_top import sbo_pkg::*; #(
  parameter int unsigned MAX_SLOTS = 512
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  req_t                  req_data,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output rsp_t                  rsp_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  sbo_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  sbo_dp #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req_data  (req_data),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
  );

`ifndef SYNTH
  // one request in flight: busy right after a request is taken
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("request accepted while previous one still in flight");

  // a scan decides once, then leaves the scan state
  a_single_decide: assert property (@(posedge clk) disable iff (rst)
    sts.decided |=> !sts.decided)
    else $error("scan decided twice for one request");

  // failed requests report no offset
  a_err_no_offset: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_data.status != ST_OK) |-> (rsp_data.byte_offset == '0))
    else $error("error result carries a byte offset");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_data.used_count <= CNT_W'(SLOT_LIMIT)))
    else $error("used count above slot limit");
`endif

endmodule

// ===== rtl/sbo_dp.sv =====
// sbo_dp: datapath of the slab allocator: config registers, bitmap word memory,
// first-fit word check, used count, offset multiplier and result register
// depends on sbo_pkg
module sbo_dp import sbo_pkg::*; #(
  parameter int unsigned MAX_SLOTS = 512
) (
  input  logic                  clk,
  input  logic                  rst,
  input  req_t                  req_data,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  dp_cmd_t               cmd,
  output dp_sts_t               sts,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output rsp_t                  rsp_data
);

  localparam int unsigned NSLOT = (MAX_SLOTS < SLOT_LIMIT) ? MAX_SLOTS : SLOT_LIMIT;
  localparam int unsigned NWORD = (NSLOT + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned WW    = (NWORD > 1) ? $clog2(NWORD) : 1;
  localparam logic [WW-1:0]     LAST_W    = WW'(NWORD - 1);
  localparam logic [SLOT_W-1:0] LAST_W_S  = SLOT_W'(NWORD - 1);
  localparam logic [CNT_W-1:0]  NSLOT_C   = CNT_W'(NSLOT);

  // configuration
  logic [CNT_W-1:0] slots_cfg;
  logic [OBJ_W-1:0] obj_cfg;
  logic [CNT_W-1:0] lim;

  // bitmap storage, one valid bit per word stands in for the reset clear
  logic [WORD_BITS-1:0] mem [NWORD];
  logic [NWORD-1:0]     wvalid;
  logic [WORD_BITS-1:0] rd_word;
  logic                 rd_wv;

  // item and scan registers
  logic              kind_r;
  logic [SLOT_W-1:0] req_r;
  logic [WW-1:0]     ptr;
  logic [WW-1:0]     chk_ptr;
  logic              chk_vld;
  logic [CNT_W-1:0]  used;

  // result registers
  logic [1:0]        res_status;
  logic [SLOT_W-1:0] res_slot;
  logic [SLOT_W-1:0] mul_slot;
  logic [PROD_W-1:0] prod;
  logic [1:0]        occ;

  // check stage signals
  logic [WORD_BITS-1:0] rd_eff;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] free_vec;
  logic [WORD_BITS-1:0] low;
  logic [BIT_W-1:0]     bit_idx;
  logic [BASE_W-1:0]    base;
  logic [BASE_W-1:0]    rem;
  logic                 found;
  logic                 last_word;
  logic                 decided;

  // commit signals
  logic                 wr_en;
  logic [WORD_BITS-1:0] wr_word;
  logic [CNT_W-1:0]     used_next;
  logic [1:0]           res_status_next;
  logic [SLOT_W-1:0]    res_slot_next;
  logic [SLOT_W-1:0]    mul_slot_next;
  logic [OFF_W-1:0]     off_sat;

  assign lim = (slots_cfg > NSLOT_C) ? NSLOT_C : slots_cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_cfg <= SLOTS_RESET;
      obj_cfg   <= OBJ_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SLOTS_IN_USE: slots_cfg <= cfg_data[CNT_W-1:0];
        CFG_OBJECT_BYTES: obj_cfg   <= cfg_data[OBJ_W-1:0];
        default: ;
      endcase
    end
  end

  // word check: mask off slots at or above the limit, find lowest clear bit
  always_comb begin
    rd_eff   = rd_wv ? rd_word : '0;
    base     = BASE_W'(chk_ptr) << BIT_W;
    rem      = {1'b0, lim} - base;
    if (base >= {1'b0, lim}) begin
      mask = '0;
    end else if (rem >= BASE_W'(WORD_BITS)) begin
      mask = '1;
    end else begin
      mask = (WORD_BITS'(1) << rem[BIT_W-1:0]) - WORD_BITS'(1);
    end
    free_vec  = ~rd_eff & mask;
    low       = free_vec & (~free_vec + WORD_BITS'(1));
    found     = |free_vec;
    last_word = (base + BASE_W'(WORD_BITS)) >= {1'b0, lim};
    bit_idx   = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      if (low[b]) bit_idx = bit_idx | BIT_W'(b);
    end
  end

  assign decided     = cmd.scan && chk_vld && (kind_r || found || last_word);
  assign sts.decided = decided;
  assign sts.out_free = !rsp_valid || !rsp_stall;

  always_comb begin
    wr_en           = 1'b0;
    wr_word         = rd_eff;
    used_next       = used;
    res_status_next = ST_OK;
    res_slot_next   = req_r;
    mul_slot_next   = '0;
    if (kind_r == KIND_ALLOC) begin
      if (found) begin
        wr_en         = decided;
        wr_word       = rd_eff | low;
        used_next     = used + CNT_W'(1);
        res_slot_next = SLOT_W'({chk_ptr, bit_idx});
        mul_slot_next = SLOT_W'({chk_ptr, bit_idx});
      end else begin
        res_status_next = ST_NO_SLOT;
        res_slot_next   = '0;
      end
    end else begin
      if ({1'b0, req_r} >= lim) begin
        res_status_next = ST_RANGE;
      end else if (!rd_eff[req_r[BIT_W-1:0]]) begin
        res_status_next = ST_DOUBLE_FREE;
      end else begin
        wr_en         = decided;
        wr_word       = rd_eff & ~(WORD_BITS'(1) << req_r[BIT_W-1:0]);
        used_next     = (used != '0) ? used - CNT_W'(1) : used;
        mul_slot_next = req_r;
      end
    end
  end

  assign off_sat = prod[PROD_W-1:OFF_W] != '0 ? OFFSET_MAX : prod[OFF_W-1:0];

  // bitmap memory, registered read
  always_ff @(posedge clk) begin
    rd_word <= mem[ptr];
    rd_wv   <= wvalid[ptr];
    if (wr_en) begin
      mem[chk_ptr] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wvalid    <= '0;
      used      <= '0;
      chk_vld   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      chk_vld <= cmd.scan && !decided;
      if (wr_en) begin
        wvalid[chk_ptr] <= 1'b1;
      end
      if (decided) begin
        used <= used_next;
      end
      if (cmd.emit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    chk_ptr <= ptr;
    if (cmd.load) begin
      kind_r <= req_data.kind;
      req_r  <= req_data.slot_index;
      if (req_data.kind == KIND_ALLOC) begin
        ptr <= '0;
      end else if ((req_data.slot_index >> BIT_W) > LAST_W_S) begin
        ptr <= LAST_W;
      end else begin
        ptr <= WW'(req_data.slot_index >> BIT_W);
      end
    end else if (cmd.scan && kind_r == KIND_ALLOC && ptr != LAST_W) begin
      ptr <= ptr + WW'(1);
    end
    if (decided) begin
      res_status <= res_status_next;
      res_slot   <= res_slot_next;
      mul_slot   <= mul_slot_next;
    end
    if (cmd.mult) begin
      prod <= PROD_W'(mul_slot) * PROD_W'(obj_cfg);
      if (used == '0) begin
        occ <= OCC_EMPTY;
      end else if (used >= lim) begin
        occ <= OCC_FULL;
      end else begin
        occ <= OCC_PARTIAL;
      end
    end
    if (cmd.emit) begin
      rsp_data.status      <= res_status;
      rsp_data.slot_out    <= res_slot;
      rsp_data.byte_offset <= off_sat;
      rsp_data.slab_state  <= occ;
      rsp_data.used_count  <= used;
    end
  end

endmodule

// ===== rtl/sbo_ctrl.sv =====
// sbo_ctrl: controller of the slab allocator; sequences load, bitmap scan,
// offset multiply and result hand-off; depends on sbo_pkg
module sbo_ctrl import sbo_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  output logic    req_stall,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_MULT,
    S_EMIT
  } state_t;

  state_t state;

  always_comb begin
    cmd.load  = (state == S_IDLE) && req_valid;
    cmd.scan  = (state == S_SCAN);
    cmd.mult  = (state == S_MULT);
    cmd.emit  = (state == S_EMIT) && sts.out_free;
    req_stall = (state != S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_valid) state <= S_SCAN;
        end
        S_SCAN: begin
          if (sts.decided) state <= S_MULT;
        end
        S_MULT: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          // wait for the result register to drain
          if (sts.out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== tb/sv/slab_bitmap_object_allocator_top_test.sv =====
// testbench for slab_bitmap_object_allocator_top: first-fit slot allocation, frees, errors,
// slab state and saturated offsets, checked against an in-bench slab model
// depends on sbo_pkg and the allocator rtl
module slab_bitmap_object_allocator_top_test;
  import sbo_pkg::*;

  localparam int unsigned MAX_SLOTS      = 512;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned TAIL_CYCLES    = 20;
  localparam int unsigned PRINT_LIMIT    = 100;

  logic                  clk;
  logic                  rst;
  logic                  req_valid;
  logic                  req_stall;
  req_t                  req_data;
  logic                  rsp_valid;
  logic                  rsp_stall;
  rsp_t                  rsp_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // slab model state
  logic [SLOT_LIMIT-1:0] slot_map = '0;
  int unsigned           used_slots = 0;
  logic [CNT_W-1:0]      slot_cap = SLOTS_RESET;
  logic [OBJ_W-1:0]      obj_bytes = OBJ_RESET;

  rsp_t        pending_results[$];
  rsp_t        next_result;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned hold_reqs = 0;

  slab_bitmap_object_allocator_top #(
    .MAX_SLOTS(MAX_SLOTS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req_data(req_data),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp_data(rsp_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int unsigned idle_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [OFF_W-1:0] slot_offset(input int unsigned slot);
    longint unsigned prod;
    prod = longint'(slot) * longint'(obj_bytes);
    if (prod > longint'(OFFSET_MAX)) return OFFSET_MAX;
    return prod[OFF_W-1:0];
  endfunction

  // applies one request to the slab model and returns the result it must give
  function automatic rsp_t predict_step(input req_t r);
    rsp_t        res;
    int unsigned lim;
    int unsigned hit;
    res = '0;
    lim = (slot_cap > MAX_SLOTS) ? MAX_SLOTS : int'(slot_cap);
    if (lim > SLOT_LIMIT) lim = SLOT_LIMIT;
    hit = lim;
    if (r.kind == KIND_ALLOC) begin
      for (int unsigned i = 0; i < lim; i++) begin
        if (!slot_map[i] && hit == lim) hit = i;
      end
      if (hit < lim) begin
        slot_map[hit] = 1'b1;
        used_slots++;
        res.slot_out = SLOT_W'(hit);
        res.byte_offset = slot_offset(hit);
      end else begin
        res.status = ST_NO_SLOT;
      end
    end else begin
      res.slot_out = r.slot_index;
      if (r.slot_index >= lim) begin
        res.status = ST_RANGE;
      end else if (!slot_map[r.slot_index]) begin
        res.status = ST_DOUBLE_FREE;
      end else begin
        slot_map[r.slot_index] = 1'b0;
        if (used_slots > 0) used_slots--;
        res.byte_offset = slot_offset(r.slot_index);
      end
    end
    if (used_slots == 0) res.slab_state = OCC_EMPTY;
    else if (used_slots >= lim) res.slab_state = OCC_FULL;
    else res.slab_state = OCC_PARTIAL;
    res.used_count = CNT_W'(used_slots);
    return res;
  endfunction

  function automatic int unsigned pick_used_slot();
    int unsigned start;
    start = $urandom_range(0, SLOT_LIMIT - 1);
    for (int unsigned i = 0; i < SLOT_LIMIT; i++) begin
      if (slot_map[(start + i) % SLOT_LIMIT]) return (start + i) % SLOT_LIMIT;
    end
    return start;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (mismatch_count < PRINT_LIMIT)
      $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic send_req(input logic kind, input logic [SLOT_W-1:0] idx,
                          input int unsigned gap);
    req_t r;
    r.kind = kind;
    r.slot_index = idx;
    req_data <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    pending_results.push_back(predict_step(r));
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drain();
    req_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // writes both registers back to back; only called with the block idle
  task automatic set_config(input logic [CFG_DATA_W-1:0] slots_word,
                            input logic [CFG_DATA_W-1:0] size_word);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_SLOTS_IN_USE;
    cfg_data <= slots_word;
    do @(posedge clk); while (!cfg_ready);
    slot_cap = slots_word[CNT_W-1:0];
    cfg_index <= CFG_OBJECT_BYTES;
    cfg_data <= size_word;
    do @(posedge clk); while (!cfg_ready);
    obj_bytes = size_word[OBJ_W-1:0];
    cfg_valid <= 1'b0;
  endtask

  task automatic test_directed_cases();
    // reset config: 512 slots of 8 bytes
    send_req(KIND_ALLOC, 9'd0, idle_gap());
    send_req(KIND_ALLOC, 9'd511, idle_gap());
    send_req(KIND_FREE, 9'd511, idle_gap());
    send_req(KIND_FREE, 9'd1, idle_gap());
    wait_drain();
    // two slots: fill, full slab, out of range, double free
    set_config(13'd2, 13'd4096);
    send_req(KIND_ALLOC, 9'h1FF, idle_gap());
    send_req(KIND_ALLOC, 9'd0, idle_gap());
    send_req(KIND_FREE, 9'd2, idle_gap());
    send_req(KIND_FREE, 9'd0, idle_gap());
    send_req(KIND_FREE, 9'd0, idle_gap());
    send_req(KIND_ALLOC, 9'd0, idle_gap());
    wait_drain();
    // oversized count with junk upper bits caps at 512, largest object size
    set_config(13'h1FFF, 13'd8191);
    send_req(KIND_ALLOC, 9'd0, idle_gap());
    send_req(KIND_FREE, 9'd1, idle_gap());
    send_req(KIND_ALLOC, 9'd0, idle_gap());
    wait_drain();
    // zero slots while slots are still in use
    set_config(13'd0, 13'd0);
    send_req(KIND_ALLOC, 9'd0, idle_gap());
    send_req(KIND_FREE, 9'd0, idle_gap());
    wait_drain();
    // limit shrunk below the used count
    set_config(13'd1, 13'd8);
    send_req(KIND_FREE, 9'd2, idle_gap());
    send_req(KIND_FREE, 9'd0, idle_gap());
    send_req(KIND_ALLOC, 9'd0, idle_gap());
    wait_drain();
  endtask

  // every slot taken with the largest size (offsets saturate), then freed in random order
  task automatic test_full_slab();
    int unsigned free_order[SLOT_LIMIT];
    int unsigned j;
    int unsigned t;
    set_config(13'd512, 13'd8191);
    while (used_slots < SLOT_LIMIT)
      send_req(KIND_ALLOC, SLOT_W'($urandom), idle_gap());
    send_req(KIND_ALLOC, SLOT_W'($urandom), idle_gap());
    send_req(KIND_ALLOC, SLOT_W'($urandom), idle_gap());
    for (int unsigned i = 0; i < SLOT_LIMIT; i++) free_order[i] = i;
    for (int unsigned i = SLOT_LIMIT - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = free_order[i];
      free_order[i] = free_order[j];
      free_order[j] = t;
    end
    for (int unsigned i = 0; i < SLOT_LIMIT; i++)
      send_req(KIND_FREE, SLOT_W'(free_order[i]), idle_gap());
    send_req(KIND_FREE, SLOT_W'(free_order[0]), idle_gap());
    wait_drain();
  endtask

  // receiver holds off while requests keep coming, then the sender waits for all results
  task automatic test_input_backpressure();
    hold_reqs <= hold_reqs + 1;
    for (int unsigned i = 0; i < 16; i++) begin
      if (i % 3 == 2) send_req(KIND_FREE, SLOT_W'(pick_used_slot()), 0);
      else send_req(KIND_ALLOC, SLOT_W'($urandom), 0);
    end
    wait_drain();
  endtask

  task automatic test_random_phases();
    logic [CFG_DATA_W-1:0] slots_word;
    logic [CFG_DATA_W-1:0] size_word;
    int unsigned           alloc_pct;
    int unsigned           r;
    for (int unsigned phase = 0; phase < 8; phase++) begin
      case ($urandom_range(0, 6))
        0: slots_word = 13'd1;
        1: slots_word = 13'd512;
        2: slots_word = 13'd0;
        3: slots_word = CFG_DATA_W'($urandom_range(513, 8191));
        default: slots_word = CFG_DATA_W'($urandom_range(2, 511));
      endcase
      case ($urandom_range(0, 5))
        0: size_word = 13'd0;
        1: size_word = 13'd8;
        2: size_word = 13'd4096;
        3: size_word = 13'd8191;
        default: size_word = CFG_DATA_W'($urandom_range(8, 4096));
      endcase
      case ($urandom_range(0, 3))
        0: alloc_pct = 20;
        1: alloc_pct = 50;
        2: alloc_pct = 80;
        default: alloc_pct = 97;
      endcase
      set_config(slots_word, size_word);
      for (int unsigned i = 0; i < 125; i++) begin
        r = $urandom_range(0, 99);
        if (r < alloc_pct)
          send_req(KIND_ALLOC, SLOT_W'($urandom), idle_gap());
        else if ($urandom_range(0, 99) < 85)
          send_req(KIND_FREE, SLOT_W'(pick_used_slot()), idle_gap());
        else
          send_req(KIND_FREE, SLOT_W'($urandom), idle_gap());
      end
      wait_drain();
    end
  endtask

  // result side: random stall runs, plus a long hold when a test asks for one
  initial begin : rsp_stall_gen
    int unsigned stall_left;
    int unsigned pass_left;
    int unsigned hold_seen;
    stall_left = 0;
    pass_left = 0;
    hold_seen = 0;
    rsp_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        stall_left = HOLD_CYCLES;
        pass_left = 0;
      end
      if (stall_left > 0) begin
        rsp_stall <= 1'b1;
        stall_left--;
      end else if (pass_left > 0) begin
        rsp_stall <= 1'b0;
        pass_left--;
      end else begin
        stall_left = idle_gap();
        pass_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 200)
                                                : $urandom_range(1, 12);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request pending, slot", rsp_data.slot_out, 0);
      end else begin
        next_result = pending_results.pop_front();
        if (rsp_data.status != next_result.status)
          report_mismatch("status", rsp_data.status, next_result.status);
        if (rsp_data.slot_out != next_result.slot_out)
          report_mismatch("slot_out", rsp_data.slot_out, next_result.slot_out);
        if (rsp_data.byte_offset != next_result.byte_offset)
          report_mismatch("byte_offset", rsp_data.byte_offset, next_result.byte_offset);
        if (rsp_data.slab_state != next_result.slab_state)
          report_mismatch("slab_state", rsp_data.slab_state, next_result.slab_state);
        if (rsp_data.used_count != next_result.used_count)
          report_mismatch("used_count", rsp_data.used_count, next_result.used_count);
      end
    end
  end

  // no handshake of any kind for too long means the block hung
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req_data = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_SLOTS_IN_USE;
    cfg_data = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_full_slab();
    test_input_backpressure();
    test_random_phases();
    wait_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
